// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/pxe_pkg.sv -----
// ---------------------------------------------------------------------------
// Postfix evaluator package
// Token and result request types, codes and cell control.
// ---------------------------------------------------------------------------
package pxe_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [1:0] KIND_NUMBER   = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_FEW_OPERANDS  = 3'd1;
  localparam logic [2:0] ST_DIV_ZERO      = 3'd2;
  localparam logic [2:0] ST_UNEXPECTED    = 3'd3;
  localparam logic [2:0] ST_FEW_OPERATORS = 3'd4;
  localparam logic [2:0] ST_OVERFLOW      = 3'd5;

  typedef struct packed {
    logic [1:0]         token_kind;
    logic signed [31:0] number_value;
    logic [1:0]         op_code;
    logic               last_token;
  } tok_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } res_req_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- design/pxe_cell.sv -----
// ---------------------------------------------------------------------------
// Stack cell
// One operand word; shifts deeper on push, shallower on pop.
// ---------------------------------------------------------------------------
module pxe_cell (
  input  logic              clk,
  input  pxe_pkg::cell_ctl_t ctl,
  input  pxe_pkg::word_t    prev,
  input  pxe_pkg::word_t    next,
  output pxe_pkg::word_t    q
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= prev;
    end else if (ctl.pop) begin
      q <= next;
    end
  end

endmodule

// ----- design/pxe_div.sv -----
// ---------------------------------------------------------------------------
// Signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pxe_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pxe_pkg::word_t dividend,
  input  pxe_pkg::word_t divisor,
  output logic           done,
  output pxe_pkg::word_t quotient
);

  localparam int STEPS = pxe_pkg::WORD_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  pxe_pkg::word_t            rem;
  pxe_pkg::word_t            quo;
  pxe_pkg::word_t            dvs;
  logic                      neg;
  logic [pxe_pkg::WORD_W:0]  rem_sh;
  logic [pxe_pkg::WORD_W:0]  diff;
  pxe_pkg::word_t            mag_a;
  pxe_pkg::word_t            mag_b;

  assign mag_a  = dividend[pxe_pkg::WORD_W-1] ? -dividend : dividend;
  assign mag_b  = divisor[pxe_pkg::WORD_W-1] ? -divisor : divisor;
  assign rem_sh = {rem, quo[pxe_pkg::WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign quotient = neg ? -quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= mag_a;
        dvs  <= mag_b;
        neg  <= dividend[pxe_pkg::WORD_W-1] ^ divisor[pxe_pkg::WORD_W-1];
      end else if (busy) begin
        if (!diff[pxe_pkg::WORD_W]) begin
          rem <= diff[pxe_pkg::WORD_W-1:0];
          quo <= {quo[pxe_pkg::WORD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[pxe_pkg::WORD_W-1:0];
          quo <= {quo[pxe_pkg::WORD_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_IMPL(a_start_idle, start, !busy)
  `ASSERT_NEXT(a_start_busy, start, busy)
  `ASSERT_NEXT(a_done_once, done, !done)

endmodule

// ----- design/postfix_expression_evaluator_unit.sv -----
// ---------------------------------------------------------------------------
// Postfix expression evaluator
// Operand stack as a row of shifting cells with add, subtract, multiply and
// a sequential divider; one result request per expression.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  tok     | tok_valid/tok_stall  | pxe_pkg::tok_req_t
//  res     | res_valid/res_stall  | pxe_pkg::res_req_t
//  cfg     | cfg_valid/cfg_ready  | cfg_data (skip_unknown)
//
//  Numbers and unknown tokens finish in S_IDLE; add, sub, mul then use S_WB.
//  Divide waits in S_DIV for the one-bit-per-cycle divider, then S_WB.
//  A last token adds S_FIN, plus any wait while a prior result is stalled.
//  Synchronous reset empties the stack and clears the error; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  output logic              tok_stall,
  input  pxe_pkg::tok_req_t tok,
  output logic              res_valid,
  input  logic              res_stall,
  output pxe_pkg::res_req_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_WB, S_FIN} state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [2:0]            err;
  logic                  skip;
  logic                  last_q;
  pxe_pkg::word_t        alu_res;

  pxe_pkg::word_t        cell_q [STACK_DEPTH];
  pxe_pkg::cell_ctl_t    ctl [STACK_DEPTH];
  pxe_pkg::word_t        top_in;

  logic                  accept;
  logic                  is_num;
  logic                  is_op;
  logic                  full;
  logic                  few;
  logic                  do_push;
  logic                  do_wb;
  logic                  do_alu;
  logic                  div_zero;
  logic                  div_start;
  logic                  div_done;
  pxe_pkg::word_t        div_quo;
  logic                  fin_fire;
  state_t                tok_next;
  pxe_pkg::res_req_t     res_next;

  assign cfg_ready = 1'b1;
  assign tok_stall = (state != S_IDLE);
  assign accept    = tok_valid && !tok_stall;
  assign is_num    = (tok.token_kind == pxe_pkg::KIND_NUMBER);
  assign is_op     = (tok.token_kind == pxe_pkg::KIND_OPERATOR);
  assign full      = (count >= CNT_W'(STACK_DEPTH));
  assign few       = (count < CNT_W'(2));
  assign do_push   = accept && (err == pxe_pkg::ST_OK) && is_num && !full;
  assign do_wb     = (state == S_WB);
  assign div_zero  = (cell_q[0] == '0);
  assign do_alu    = accept && (err == pxe_pkg::ST_OK) && is_op && !few &&
                     (tok.op_code != pxe_pkg::OP_DIV);
  assign div_start = accept && (err == pxe_pkg::ST_OK) && is_op && !few &&
                     (tok.op_code == pxe_pkg::OP_DIV) && !div_zero;
  assign fin_fire  = (state == S_FIN) && (!res_valid || !res_stall);
  assign tok_next  = tok.last_token ? S_FIN : S_IDLE;
  assign top_in    = do_wb ? alu_res : pxe_pkg::word_t'(tok.number_value);

  always_comb begin
    res_next.result_value = '0;
    res_next.status       = err;
    if (err == pxe_pkg::ST_OK) begin
      if (count == '0) begin
        res_next.status = pxe_pkg::ST_FEW_OPERANDS;
      end else if (count > CNT_W'(1)) begin
        res_next.status = pxe_pkg::ST_FEW_OPERATORS;
      end else begin
        res_next.result_value = signed'(cell_q[0]);
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      pxe_pkg::word_t prev_d;
      pxe_pkg::word_t next_d;
      if (i == 0) begin : g_top
        assign prev_d    = top_in;
        assign ctl[i]    = '{push: do_push || do_wb, pop: 1'b0};
      end else begin : g_body
        assign prev_d    = cell_q[i-1];
        assign ctl[i]    = '{push: do_push, pop: do_wb};
      end
      if (i == STACK_DEPTH - 1) begin : g_end
        assign next_d = '0;
      end else begin : g_mid
        assign next_d = cell_q[i+1];
      end
      pxe_cell u_cell (
        .clk  (clk),
        .ctl  (ctl[i]),
        .prev (prev_d),
        .next (next_d),
        .q    (cell_q[i])
      );
    end
  endgenerate

  pxe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cell_q[1]),
    .divisor  (cell_q[0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= pxe_pkg::ST_OK;
      skip      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        skip <= cfg_data;
      end
      if (fin_fire) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= tok.last_token;
            if (div_start) begin
              state <= S_DIV;
            end else if (do_alu) begin
              state <= S_WB;
            end else begin
              state <= tok_next;
            end
            if (err == pxe_pkg::ST_OK) begin
              priority if (is_num) begin
                if (full) begin
                  err <= pxe_pkg::ST_OVERFLOW;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end else if (is_op) begin
                if (few) begin
                  err <= pxe_pkg::ST_FEW_OPERANDS;
                end else begin
                  unique case (tok.op_code)
                    pxe_pkg::OP_ADD: begin
                      alu_res <= cell_q[1] + cell_q[0];
                    end
                    pxe_pkg::OP_SUB: begin
                      alu_res <= cell_q[1] - cell_q[0];
                    end
                    pxe_pkg::OP_MUL: begin
                      alu_res <= cell_q[1] * cell_q[0];
                    end
                    pxe_pkg::OP_DIV: begin
                      if (div_zero) begin
                        err <= pxe_pkg::ST_DIV_ZERO;
                      end
                    end
                  endcase
                end
              end else begin
                if (!skip) begin
                  err <= pxe_pkg::ST_UNEXPECTED;
                end
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            alu_res <= div_quo;
            state   <= S_WB;
          end
        end
        S_WB: begin
          count <= count - CNT_W'(1);
          state <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (fin_fire) begin
            res       <= res_next;
            count     <= '0;
            err       <= pxe_pkg::ST_OK;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(STACK_DEPTH))
  `ASSERT_IMPL(a_div_done_state, div_done, state == S_DIV)
  `ASSERT_NEXT(a_fin_clears, fin_fire, count == '0 && err == pxe_pkg::ST_OK && res_valid)
  `ASSERT_IMPL(a_wb_has_operands, do_wb, count >= CNT_W'(2))

endmodule

// ----- tb/sv/postfix_expression_evaluator_unit_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Drives token requests through the evaluator and predicts every result
// request with a scoreboard that keeps its own operand stack. A short
// directed set covers the extremes and error paths. Random expressions
// follow: well formed, noisy, broken, empty and deep. The skip mode is
// switched between phases while the block is idle, and both channels idle
// and stall at random.
// ---------------------------------------------------------------------------
module postfix_expression_evaluator_unit_test;

  localparam int          STACK_DEPTH   = 64;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned PHASE_TOKENS  = 205;

  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  localparam int SHAPE_CLEAN  = 0;
  localparam int SHAPE_NOISY  = 1;
  localparam int SHAPE_BROKEN = 2;
  localparam int SHAPE_EMPTY  = 3;
  localparam int SHAPE_DEEP   = 4;

  class rpn_value_board;
    logic signed [31:0] operands [STACK_DEPTH];
    int unsigned        depth;
    logic [2:0]         latched;
    logic               skip;
    pxe_pkg::res_req_t  pending_values [$];
    int unsigned        tokens;
    int unsigned        exprs;
    int unsigned        mismatches;
    int unsigned        status_tally [8];

    function new();
      depth = 0;
      latched = pxe_pkg::ST_OK;
      skip = 1'b0;
      tokens = 0;
      exprs = 0;
      mismatches = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void absorb_token(pxe_pkg::tok_req_t t);
      logic [1:0]         kind;
      logic signed [31:0] lhs;
      logic signed [31:0] rhs;
      logic signed [31:0] val;
      pxe_pkg::res_req_t  r;
      tokens++;
      kind = (t.token_kind == KIND_SPARE) ? KIND_UNKNOWN : t.token_kind;
      val = '0;
      if (latched == pxe_pkg::ST_OK) begin
        if (kind == pxe_pkg::KIND_NUMBER) begin
          if (depth >= STACK_DEPTH) begin
            latched = pxe_pkg::ST_OVERFLOW;
          end else begin
            operands[depth] = t.number_value;
            depth++;
          end
        end else if (kind == pxe_pkg::KIND_OPERATOR) begin
          if (depth < 2) begin
            latched = pxe_pkg::ST_FEW_OPERANDS;
          end else begin
            rhs = operands[depth-1];
            lhs = operands[depth-2];
            case (t.op_code)
              pxe_pkg::OP_ADD: val = lhs + rhs;
              pxe_pkg::OP_SUB: val = lhs - rhs;
              pxe_pkg::OP_MUL: val = lhs * rhs;
              default: begin
                if (rhs == 0) latched = pxe_pkg::ST_DIV_ZERO;
                else if (lhs == WORD_MIN && rhs == -1) val = lhs;
                else val = lhs / rhs;
              end
            endcase
            if (latched == pxe_pkg::ST_OK) begin
              depth--;
              operands[depth-1] = val;
            end
          end
        end else if (!skip) begin
          latched = pxe_pkg::ST_UNEXPECTED;
        end
      end
      if (t.last_token) begin
        r.result_value = '0;
        r.status = latched;
        if (latched == pxe_pkg::ST_OK) begin
          if (depth == 0) r.status = pxe_pkg::ST_FEW_OPERANDS;
          else if (depth > 1) r.status = pxe_pkg::ST_FEW_OPERATORS;
          else r.result_value = operands[0];
        end
        pending_values = {pending_values, r};
        exprs++;
        status_tally[r.status]++;
        depth = 0;
        latched = pxe_pkg::ST_OK;
      end
    endfunction

    function void match_result(pxe_pkg::res_req_t got);
      pxe_pkg::res_req_t want;
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unrequested result value=%0d status=%0d",
                   got.result_value, got.status);
        return;
      end
      want = pending_values.pop_front();
      if (got.result_value !== want.result_value || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: value exp %0d got %0d, status exp %0d got %0d",
                   exprs - pending_values.size(), want.result_value,
                   got.result_value, want.status, got.status);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              tok_valid = 1'b0;
  logic              tok_stall;
  pxe_pkg::tok_req_t tok = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  pxe_pkg::res_req_t res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              calm = 1'b0;
  int unsigned       cycle_count = 0;

  rpn_value_board board = new();

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    res_stall <= !calm && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) board.match_result(res);
      if (tok_valid && !tok_stall) board.absorb_token(tok);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return -1;
      3: return 0;
      4, 5, 6: return $signed($urandom_range(18)) - 9;
      default: return $urandom;
    endcase
  endfunction

  function automatic pxe_pkg::tok_req_t make_token(logic [1:0] kind,
                                                   logic signed [31:0] value,
                                                   logic [1:0] op, logic last);
    pxe_pkg::tok_req_t t;
    t.token_kind   = kind;
    t.number_value = (kind == pxe_pkg::KIND_NUMBER) ? value : $urandom;
    t.op_code      = (kind == pxe_pkg::KIND_OPERATOR) ? op : 2'($urandom_range(3));
    t.last_token   = last;
    return t;
  endfunction

  task automatic send_token(input pxe_pkg::tok_req_t t);
    while (!calm && $urandom_range(99) < 27) begin
      tok_valid <= 1'b0;
      @(posedge clk);
    end
    tok_valid <= 1'b1;
    tok <= t;
    @(posedge clk);
    while (tok_stall) @(posedge clk);
  endtask

  task automatic post(input logic [1:0] kind, input logic signed [31:0] value,
                      input logic [1:0] op, input logic last);
    send_token(make_token(kind, value, op, last));
  endtask

  task automatic write_skip(input logic mode);
    tok_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.skip = mode;
  endtask

  task automatic run_expression(input int shape);
    pxe_pkg::tok_req_t q [$];
    pxe_pkg::tok_req_t t;
    int unsigned       n_operands;
    int unsigned       pushed;
    int unsigned       level;
    pushed = 0;
    level = 0;
    n_operands = (shape == SHAPE_DEEP) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    if (shape == SHAPE_EMPTY) begin
      case ($urandom_range(2))
        0: q = {q, make_token(KIND_UNKNOWN, 0, 0, 1'b0)};
        1: q = {q, make_token(KIND_SPARE, 0, 0, 1'b0)};
        default: q = {q, make_token(pxe_pkg::KIND_OPERATOR, 0,
                                    2'($urandom_range(3)), 1'b0)};
      endcase
    end else begin
      while (pushed < n_operands || level > 1) begin
        if (pushed < n_operands &&
            (level < 2 || shape == SHAPE_DEEP || $urandom_range(1) == 1)) begin
          q = {q, make_token(pxe_pkg::KIND_NUMBER, pick_value(), 0, 1'b0)};
          pushed++;
          level++;
        end else begin
          q = {q, make_token(pxe_pkg::KIND_OPERATOR, 0, 2'($urandom_range(3)), 1'b0)};
          level--;
        end
      end
      if (shape == SHAPE_BROKEN) begin
        if ($urandom_range(1) == 1 && q.size() > 1) void'(q.pop_back());
        else q = {q, make_token(pxe_pkg::KIND_OPERATOR, 0, 2'($urandom_range(3)), 1'b0)};
      end
    end
    t = q.pop_back();
    t.last_token = 1'b1;
    q = {q, t};
    foreach (q[i]) begin
      if (shape == SHAPE_NOISY && $urandom_range(4) == 0)
        post($urandom_range(1) ? KIND_UNKNOWN : KIND_SPARE, 0, 0, 1'b0);
      send_token(q[i]);
    end
  endtask

  task automatic run_phase(input logic mode, input logic quiet);
    int unsigned start;
    int unsigned pick;
    write_skip(mode);
    calm <= quiet;
    start = board.tokens;
    run_expression(SHAPE_DEEP);
    while (board.tokens - start < PHASE_TOKENS) begin
      pick = $urandom_range(99);
      if (pick < 62)      run_expression(SHAPE_CLEAN);
      else if (pick < 80) run_expression(SHAPE_NOISY);
      else if (pick < 91) run_expression(SHAPE_BROKEN);
      else if (pick < 97) run_expression(SHAPE_EMPTY);
      else                run_expression(SHAPE_DEEP);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    post(pxe_pkg::KIND_NUMBER, WORD_MAX, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, WORD_MIN, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_ADD, 1'b1);
    post(pxe_pkg::KIND_NUMBER, WORD_MAX, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 1, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_ADD, 1'b1);
    post(pxe_pkg::KIND_NUMBER, WORD_MIN, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 1, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_SUB, 1'b1);
    post(pxe_pkg::KIND_NUMBER, WORD_MAX, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 2, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_MUL, 1'b1);
    post(pxe_pkg::KIND_NUMBER, -7, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 2, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_DIV, 1'b1);
    post(pxe_pkg::KIND_NUMBER, WORD_MIN, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, -1, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_DIV, 1'b1);
    post(pxe_pkg::KIND_NUMBER, 5, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 0, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_DIV, 1'b1);
    post(pxe_pkg::KIND_NUMBER, 1, 0, 1'b0);
    post(pxe_pkg::KIND_OPERATOR, 0, pxe_pkg::OP_ADD, 1'b1);
    post(KIND_UNKNOWN, 0, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 5, 0, 1'b1);
    post(KIND_SPARE, 0, 0, 1'b1);
    post(pxe_pkg::KIND_NUMBER, 1, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, 2, 0, 1'b1);

    write_skip(1'b1);
    post(KIND_UNKNOWN, 0, 0, 1'b0);
    post(pxe_pkg::KIND_NUMBER, -3, 0, 1'b1);
    post(KIND_SPARE, 0, 0, 1'b1);

    run_phase(1'b0, 1'b0);
    run_phase(1'b1, 1'b1);
    run_phase(1'b1, 1'b0);
    run_phase(1'b0, 1'b0);

    tok_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d tokens in %0d expressions, skip mode off and on, %0d mismatches",
             board.tokens, board.exprs, board.mismatches);
    $display("statuses: ok %0d, few operands %0d, div zero %0d, unexpected %0d, %s %0d, %s %0d",
             board.status_tally[pxe_pkg::ST_OK],
             board.status_tally[pxe_pkg::ST_FEW_OPERANDS],
             board.status_tally[pxe_pkg::ST_DIV_ZERO],
             board.status_tally[pxe_pkg::ST_UNEXPECTED],
             "few operators", board.status_tally[pxe_pkg::ST_FEW_OPERATORS],
             "overflow", board.status_tally[pxe_pkg::ST_OVERFLOW]);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
